// File: src/qtip_pkg.sv
// ----------------------------------------------------------------------------
// qtip_pkg
// types and constants shared by the top-k inner product search block
// ----------------------------------------------------------------------------
package qtip_pkg;

    // accumulator and score width; the scale saturation check is built for 48
    localparam int unsigned ACC_WIDTH = 48;
    localparam int unsigned SCORE_W   = ACC_WIDTH;
    localparam int unsigned ID_W      = 32;

    localparam logic [1:0] REQ_QUERY = 2'd0;
    localparam logic [1:0] REQ_ROW   = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;

    localparam logic [1:0] FMT_FIXED = 2'd0;
    localparam logic [1:0] FMT_INT8  = 2'd1;
    localparam logic [1:0] FMT_INT4  = 2'd2;

    localparam logic [1:0] CFG_VEC_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_RESULT_COUNT = 2'd1;
    localparam logic [1:0] CFG_CODE_FORMAT  = 2'd2;

    localparam logic [3:0] NIBBLE_MASK = 4'hf;

    typedef struct packed {
        logic [1:0]  req_type;
        logic signed [15:0] elem_value;
        logic [31:0] cand_id;
        logic [31:0] cand_scale;
        logic        slot_live;
    } t_in_beat;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score_out;
        logic [ID_W-1:0]           id_out;
        logic                      last;
    } t_out_beat;

endpackage

// File: src/qtip_ram.sv
// ----------------------------------------------------------------------------
// qtip_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module qtip_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/quantized_topk_inner_product.sv
// ----------------------------------------------------------------------------
// quantized_topk_inner_product
// top-k maximum inner product search over fixed, int8 or int4 coded rows
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | beat
//  --------+-----------+--------------------+---------------------------------
//  input   | in        | i_valid / o_stall  | t_in_beat: query, row elem, flush
//  output  | out       | o_valid / i_stall  | t_out_beat: score, id, last
//  config  | in        | i_cfg_valid/o_cfg_ready | register index and data
//
//  query beat: accept, then store write
//  row beat: accept, query ram read, multiply, accumulate; a live
//    row end adds the low and high scale multiplies and the scale combine
//    (int8 and int4 only), then the insertion walk
//  flush: accept, one step per result beat, one closing step; each result
//    beat waits on i_stall
//  the single multiplier is the shared unit; the top-k list is walked by
//  one compare / shift unit, one entry per cycle
//  reset is synchronous active low; the query store needs no clearing
// ----------------------------------------------------------------------------
module quantized_topk_inner_product
    import qtip_pkg::*;
#(
    parameter int DIM_MAX   = 1024,
    parameter int K_MAX     = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int AW = $clog2(DIM_MAX);
    localparam int KW = $clog2(K_MAX + 1);
    localparam int PW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_QWR    = 4'd1;
    localparam logic [3:0] S_RRD    = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_ACC    = 4'd4;
    localparam logic [3:0] S_SMUL   = 4'd5;
    localparam logic [3:0] S_SCOMB  = 4'd6;
    localparam logic [3:0] S_SEARCH = 4'd7;
    localparam logic [3:0] S_SHIFT  = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;
    localparam logic [3:0] S_SMUL2  = 4'd10;

    logic [3:0] r_state;

    // config registers
    logic [10:0] r_vec_length;
    logic [4:0]  r_result_count;
    logic [1:0]  r_code_format;

    // captured beat
    t_in_beat r_beat;

    logic [AW:0]  r_query_fill;
    logic [AW:0]  r_elem_index;
    logic signed [ACC_WIDTH-1:0] r_dot_acc;
    logic signed [31:0] r_prod;
    logic [KW-1:0] r_best_fill;

    // scale stage: magnitude split in two 32-bit halves through one multiplier
    logic         r_neg;
    logic [63:0]  r_mag;
    logic [63:0]  r_lo;
    logic [63:0]  r_hi;
    logic signed [ACC_WIDTH-1:0] r_score;

    // top-k list, best first, indexed by the walk position during search and shift
    logic signed [ACC_WIDTH-1:0] r_best_s [K_MAX];
    logic [ID_W-1:0]             r_best_id [K_MAX];
    logic [KW-1:0] r_pos;
    logic [KW-1:0] r_shift;
    logic [KW-1:0] r_k;
    logic [KW-1:0] r_n;

    // effective length and count
    logic [AW:0]   w_len;
    logic [KW-1:0] w_k;
    always_comb begin
        if (r_vec_length == 11'd0) begin
            w_len = (AW+1)'(1);
        end else if (32'(r_vec_length) > DIM_MAX) begin
            w_len = (AW+1)'(DIM_MAX);
        end else begin
            w_len = (AW+1)'(r_vec_length);
        end
        if (r_result_count == 5'd0) begin
            w_k = KW'(1);
        end else if (32'(r_result_count) > K_MAX) begin
            w_k = KW'(K_MAX);
        end else begin
            w_k = KW'(r_result_count);
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    wire w_in_acc  = i_valid && !o_stall;
    wire w_out_acc = o_valid && !i_stall;

    // query store
    logic [AW-1:0] w_qaddr_w;
    logic [AW-1:0] w_qaddr_r;
    logic [15:0]   w_qrd;
    assign w_qaddr_w = r_query_fill[AW-1:0];
    assign w_qaddr_r = r_elem_index[AW-1:0];

    qtip_ram #(.WIDTH(16), .DEPTH(DIM_MAX)) u_qram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_QWR),
        .i_waddr (w_qaddr_w),
        .i_wdata (r_beat.elem_value),
        .i_raddr (w_qaddr_r),
        .o_rdata (w_qrd)
    );

    // decoded row element
    logic signed [15:0] w_elem;
    always_comb begin
        unique case (r_code_format)
            FMT_INT8: w_elem = 16'(signed'(r_beat.elem_value[7:0]));
            FMT_INT4: w_elem = 16'(signed'({1'b0, r_beat.elem_value[3:0] & NIBBLE_MASK})) - 16'sd8;
            default:  w_elem = r_beat.elem_value;
        endcase
    end

    // shared multiplier: 32x32 unsigned, operands chosen by state
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_mp;
    always_comb begin
        if (r_state == S_MUL) begin
            w_ma = 32'(signed'(w_qrd));
            w_mb = 32'(w_elem);
        end else if (r_state == S_SMUL) begin
            w_ma = r_mag[31:0];
            w_mb = r_beat.cand_scale;
        end else begin
            w_ma = r_mag[63:32];
            w_mb = r_beat.cand_scale;
        end
        w_mp = 64'(w_ma) * 64'(w_mb);
    end

    // saturating accumulate
    logic signed [ACC_WIDTH+1:0] w_sum;
    logic signed [ACC_WIDTH-1:0] w_acc;
    always_comb begin
        w_sum = (ACC_WIDTH+2)'(r_dot_acc) + (ACC_WIDTH+2)'(r_prod);
        if (w_sum > (ACC_WIDTH+2)'(ACC_MAX)) begin
            w_acc = ACC_MAX;
        end else if (w_sum < (ACC_WIDTH+2)'(ACC_MIN)) begin
            w_acc = ACC_MIN;
        end else begin
            w_acc = w_sum[ACC_WIDTH-1:0];
        end
    end
    wire w_row_end = (r_elem_index + (AW+1)'(1)) >= w_len;
    wire w_quant   = (r_code_format == FMT_INT8) || (r_code_format == FMT_INT4);

    // scale combine
    logic [63:0] w_q;
    logic [63:0] w_lim;
    logic        w_big;
    logic signed [ACC_WIDTH-1:0] w_scaled;
    always_comb begin
        w_big = r_hi >= (64'd1 << 46);
        w_q   = (r_hi << 16) + (r_lo >> 16);
        if (r_neg && (r_lo[15:0] != 16'd0)) begin
            w_q = w_q + 64'd1;
        end
        w_lim = r_neg ? 64'(ACC_MAX) + 64'd1 : 64'(ACC_MAX);
        if (w_big || (w_q >= w_lim)) begin
            w_scaled = r_neg ? ACC_MIN : ACC_MAX;
        end else begin
            w_scaled = r_neg ? ACC_WIDTH'(-w_q) : ACC_WIDTH'(w_q);
        end
    end

    // compare unit for the insertion walk
    logic [PW-1:0] w_pidx;
    logic          w_better;
    assign w_pidx   = r_pos[PW-1:0];
    assign w_better = (r_score > r_best_s[w_pidx]) ||
                      ((r_score == r_best_s[w_pidx]) && (r_beat.cand_id < r_best_id[w_pidx]));

    logic [PW-1:0] w_sidx;
    assign w_sidx = r_shift[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_vec_length   <= 11'd64;
            r_result_count <= 5'd8;
            r_code_format  <= FMT_FIXED;
            r_query_fill   <= '0;
            r_elem_index   <= '0;
            r_dot_acc      <= '0;
            r_best_fill    <= '0;
            o_valid        <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_VEC_LENGTH:   r_vec_length   <= i_cfg_data[10:0];
                    CFG_RESULT_COUNT: r_result_count <= i_cfg_data[4:0];
                    CFG_CODE_FORMAT:  r_code_format  <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_beat <= i_data;
                        unique case (i_data.req_type)
                            REQ_QUERY: begin
                                r_state <= S_QWR;
                                if (r_query_fill >= w_len) begin
                                    r_query_fill <= '0;
                                end
                            end
                            REQ_ROW: r_state <= S_RRD;
                            REQ_FLUSH: begin
                                r_k     <= w_k;
                                r_n     <= (r_best_fill < w_k) ? r_best_fill : w_k;
                                r_pos   <= '0;
                                r_state <= S_EMIT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_QWR: begin
                    r_query_fill <= ((r_query_fill + (AW+1)'(1)) >= w_len) ? '0
                                    : r_query_fill + (AW+1)'(1);
                    r_state <= S_IDLE;
                end
                S_RRD: r_state <= S_MUL;
                S_MUL: begin
                    r_prod  <= w_mp[31:0];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (w_row_end) begin
                        r_neg        <= w_acc < 0;
                        r_mag        <= (w_acc < 0) ? 64'(-64'(w_acc)) : 64'(w_acc);
                        r_score      <= w_acc;
                        r_dot_acc    <= '0;
                        r_elem_index <= '0;
                        r_k          <= w_k;
                        r_n          <= (r_best_fill < w_k) ? r_best_fill : w_k;
                        r_pos        <= '0;
                        if (!r_beat.slot_live) begin
                            r_state <= S_IDLE;
                        end else if (w_quant) begin
                            r_state <= S_SMUL;
                        end else begin
                            r_state <= S_SEARCH;
                        end
                    end else begin
                        r_dot_acc    <= w_acc;
                        r_elem_index <= r_elem_index + (AW+1)'(1);
                        r_state      <= S_IDLE;
                    end
                end
                S_SMUL: begin
                    r_lo    <= w_mp;
                    r_state <= S_SMUL2;
                end
                S_SMUL2: begin
                    r_hi    <= w_mp;
                    r_state <= S_SCOMB;
                end
                S_SCOMB: begin
                    r_score <= w_scaled;
                    r_state <= S_SEARCH;
                end
                S_SEARCH: begin
                    // one list entry compared per cycle
                    if ((r_pos < r_n) && !w_better) begin
                        r_pos <= r_pos + KW'(1);
                    end else if (r_pos >= r_k) begin
                        r_best_fill <= r_n;
                        r_state     <= S_IDLE;
                    end else begin
                        r_shift <= (r_n < r_k) ? r_n : r_k - KW'(1);
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    // move one entry down per cycle, then drop the new one in
                    if (r_shift > r_pos) begin
                        r_best_s[w_sidx]  <= r_best_s[w_sidx - PW'(1)];
                        r_best_id[w_sidx] <= r_best_id[w_sidx - PW'(1)];
                        r_shift <= r_shift - KW'(1);
                    end else begin
                        r_best_s[w_pidx]  <= r_score;
                        r_best_id[w_pidx] <= r_beat.cand_id;
                        r_best_fill <= (r_n < r_k) ? r_n + KW'(1) : r_k;
                        r_state     <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (!o_valid || w_out_acc) begin
                        if (o_valid && o_data.last) begin
                            o_valid     <= 1'b0;
                            r_best_fill <= '0;
                            r_state     <= S_IDLE;
                        end else begin
                            o_valid          <= 1'b1;
                            o_data.score_out <= (r_pos < r_n)
                                ? SCORE_W'(r_best_s[w_pidx]) : SCORE_W'(ACC_MIN);
                            o_data.id_out    <= (r_pos < r_n) ? r_best_id[w_pidx] : '1;
                            o_data.last      <= (r_pos + KW'(1)) == r_k;
                            r_pos            <= r_pos + KW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result beats only while flushing
    a_valid_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_EMIT))
        else $error("result beat outside flush");
    // kept count never exceeds k_max
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_best_fill) <= K_MAX)
        else $error("top list overfilled");
    // a taken last beat ends the flush
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_data.last) |=> !o_valid)
        else $error("beat after last");
endmodule

// File: tb/sv/tb_quantized_topk_inner_product.sv
// ----------------------------------------------------------------------------
// tb_quantized_topk_inner_product
// self-checking bench: a directed table, a saturation sequence, then random
// query / row / flush traffic over several register settings and idle patterns,
// with every result beat compared against the in-bench top-k predictor or a
// typed expectation from the table
module tb_quantized_topk_inner_product;
    import qtip_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM_MAX = 1024;
    localparam int K_MAX   = 16;
    localparam longint SCORE_MAX = (64'sd1 <<< 47) - 1;
    localparam longint SCORE_MIN = -SCORE_MAX - 1;
    // room for a row end to finish its scale, combine and insertion walk
    localparam int SETTLE_CYCLES = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in_beat    i_data;
    logic        o_valid;
    logic        i_stall;
    t_out_beat   o_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    quantized_topk_inner_product u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // top-k predictor state: its own copy of registers, query and list
    // ------------------------------------------------------------------
    logic [10:0]        cfg_len;
    logic [4:0]         cfg_k;
    logic [1:0]         cfg_fmt;
    logic signed [15:0] query_mem [DIM_MAX];
    int unsigned        query_pos;
    int unsigned        row_pos;
    longint             row_acc;
    longint             top_score [K_MAX];
    logic [31:0]        top_id [K_MAX];
    int unsigned        top_fill;

    t_out_beat match_q[$];     // expected result beats, oldest first
    int        n_errors;
    int        n_beats_in;
    int        n_beats_out;
    int        n_flushes;
    int        send_pct;
    int        stall_pct;

    // overall time limit
    initial begin
        #20ms;
        $display("timeout with %0d result beats outstanding", match_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int unsigned active_len();
        if (cfg_len == 0) return 1;
        if (cfg_len > DIM_MAX) return DIM_MAX;
        return cfg_len;
    endfunction

    function automatic int unsigned active_k();
        if (cfg_k == 0) return 1;
        if (cfg_k > K_MAX) return K_MAX;
        return cfg_k;
    endfunction

    function automatic longint clamp_score(logic signed [95:0] v);
        if (v > SCORE_MAX) return SCORE_MAX;
        if (v < SCORE_MIN) return SCORE_MIN;
        return longint'(v);
    endfunction

    // q16.16 row scale, floor of the exact product
    function automatic longint dequant_score(longint acc, logic [31:0] scale);
        logic signed [95:0] prod;
        prod = 96'(acc);
        prod = prod * $signed({64'd0, scale});
        return clamp_score(prod >>> 16);
    endfunction

    function automatic bit ranks_above(longint s1, logic [31:0] d1,
                                       longint s2, logic [31:0] d2);
        return (s1 > s2) || (s1 == s2 && d1 < d2);
    endfunction

    function automatic void insert_match(longint s, logic [31:0] d);
        int unsigned k;
        int unsigned n;
        int unsigned p;
        int unsigned j;
        k = active_k();
        n = (top_fill < k) ? top_fill : k;
        p = 0;
        while (p < n && !ranks_above(s, d, top_score[p], top_id[p])) p++;
        if (p >= k) begin
            top_fill = n;
            return;
        end
        j = (n < k) ? n : k - 1;
        while (j > p) begin
            top_score[j] = top_score[j-1];
            top_id[j]    = top_id[j-1];
            j--;
        end
        top_score[p] = s;
        top_id[p]    = d;
        top_fill     = (n < k) ? n + 1 : k;
    endfunction

    // advance the predictor by one accepted beat, returning its results
    task automatic predict_beat(input t_in_beat b, output t_out_beat res[$]);
        int unsigned        len;
        int unsigned        k;
        int unsigned        n;
        logic signed [15:0] elem;
        longint             s;
        t_out_beat          r;
        res = {};
        len = active_len();
        case (b.req_type)
            REQ_QUERY: begin
                if (query_pos >= len) query_pos = 0;
                query_mem[query_pos] = b.elem_value;
                query_pos = (query_pos + 1 >= len) ? 0 : query_pos + 1;
            end
            REQ_ROW: begin
                if (cfg_fmt == FMT_INT8)
                    elem = 16'($signed(b.elem_value[7:0]));
                else if (cfg_fmt == FMT_INT4)
                    elem = 16'(signed'({1'b0, b.elem_value[3:0] & NIBBLE_MASK})) - 16'sd8;
                else
                    elem = b.elem_value;
                s = longint'(query_mem[row_pos]) * longint'(elem);
                row_acc = clamp_score(96'(row_acc) + 96'(s));
                if (row_pos + 1 >= len) begin
                    if (cfg_fmt == FMT_INT8 || cfg_fmt == FMT_INT4)
                        s = dequant_score(row_acc, b.cand_scale);
                    else
                        s = row_acc;
                    if (b.slot_live) insert_match(s, b.cand_id);
                    row_acc = 0;
                    row_pos = 0;
                end else begin
                    row_pos++;
                end
            end
            REQ_FLUSH: begin
                k = active_k();
                n = (top_fill < k) ? top_fill : k;
                for (int unsigned i = 0; i < k; i++) begin
                    r.score_out = (i < n) ? top_score[i][47:0] : SCORE_MIN[47:0];
                    r.id_out    = (i < n) ? top_id[i] : '1;
                    r.last      = (i + 1 == k);
                    res = {res, r};
                end
                top_fill = 0;
            end
            default: ;  // unused request code, no effect
        endcase
    endtask

    // ------------------------------------------------------------------
    // output side: random stall and result comparison
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        n_errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_beats_out++;
            if (match_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat %h", o_data));
            end else begin
                want = match_q.pop_front();
                if (o_data.score_out !== want.score_out)
                    report_mismatch($sformatf("score %0d, want %0d",
                        o_data.score_out, want.score_out));
                if (o_data.id_out !== want.id_out)
                    report_mismatch($sformatf("id %h, want %h",
                        o_data.id_out, want.id_out));
                if (o_data.last !== want.last)
                    report_mismatch($sformatf("last %b, want %b",
                        o_data.last, want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    // one beat; a typed expectation replaces the predicted single result
    task automatic send_beat(input t_in_beat b, input bit typed = 1'b0,
                             input t_out_beat typed_res = '0);
        t_out_beat res[$];
        if ($urandom_range(99) < send_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= b;
        do @(posedge i_clk); while (o_stall);
        n_beats_in++;
        predict_beat(b, res);
        if (b.req_type == REQ_FLUSH) n_flushes++;
        if (typed) match_q = {match_q, typed_res};
        else foreach (res[i]) match_q = {match_q, res[i]};
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (match_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write, only from an idle block
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_VEC_LENGTH:   cfg_len = val[10:0];
            CFG_RESULT_COUNT: cfg_k   = val[4:0];
            CFG_CODE_FORMAT:  cfg_fmt = val[1:0];
            default: ;
        endcase
    endtask

    function automatic t_in_beat mk(logic [1:0] rt, logic [15:0] v,
                                    logic [31:0] d = 0, logic [31:0] sc = 0,
                                    logic lv = 1'b1);
        t_in_beat b;
        b.req_type   = rt;
        b.elem_value = v;
        b.cand_id    = d;
        b.cand_scale = sc;
        b.slot_live  = lv;
        return b;
    endfunction

    function automatic t_out_beat res_of(longint s, logic [31:0] d);
        t_out_beat r;
        r.score_out = s[47:0];
        r.id_out    = d;
        r.last      = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    typedef enum logic { STEP_REG, STEP_BEAT } t_step_kind;

    typedef struct {
        t_step_kind  kind;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        t_in_beat    beat;
        bit          typed;
        t_out_beat   want;
    } t_step;

    t_step steps[$];

    function automatic void add_reg(logic [1:0] idx, logic [31:0] val);
        t_step s;
        s = '{kind: STEP_REG, reg_idx: idx, reg_val: val, beat: '0,
              typed: 1'b0, want: '0};
        steps = {steps, s};
    endfunction

    function automatic void add_beat(t_in_beat b, bit typed = 1'b0,
                                     t_out_beat want = '0);
        t_step s;
        s = '{kind: STEP_BEAT, reg_idx: '0, reg_val: '0, beat: b,
              typed: typed, want: want};
        steps = {steps, s};
    endfunction

    function automatic void build_table();
        // empty list after reset: one padding beat
        add_reg(CFG_RESULT_COUNT, 1);
        add_beat(mk(REQ_FLUSH, '0), 1'b1, res_of(SCORE_MIN, '1));
        add_beat(mk(2'd3, 16'hffff, '1, '1, 1'b1));     // unused request
        // fixed format, extreme query and row values
        add_reg(CFG_VEC_LENGTH, 2);
        add_reg(CFG_CODE_FORMAT, FMT_FIXED);
        add_beat(mk(REQ_QUERY, 16'h7fff));
        add_beat(mk(REQ_QUERY, 16'h8000));
        add_beat(mk(REQ_ROW, 16'h7fff, 32'd99, 0, 1'b0)); // id taken from row end
        add_beat(mk(REQ_ROW, 16'h8000, 32'd5));
        add_beat(mk(REQ_FLUSH, '0), 1'b1, res_of(64'sd2147418113, 32'd5));
        // dead row is skipped
        add_beat(mk(REQ_ROW, 16'h0001, 32'd9, 0, 1'b0));
        add_beat(mk(REQ_ROW, 16'h0001, 32'd9, 0, 1'b0));
        add_beat(mk(REQ_FLUSH, '0), 1'b1, res_of(SCORE_MIN, '1));
        // int8 codes from the low byte, unit scale
        add_reg(CFG_CODE_FORMAT, FMT_INT8);
        add_beat(mk(REQ_ROW, 16'h0080, 32'd7, 32'h0001_0000));
        add_beat(mk(REQ_ROW, 16'hff7f, 32'd7, 32'h0001_0000));
        add_beat(mk(REQ_FLUSH, '0), 1'b1, res_of(-64'sd8355712, 32'd7));
        // int4 nibble minus eight, scale of two
        add_reg(CFG_CODE_FORMAT, FMT_INT4);
        add_beat(mk(REQ_ROW, 16'h000f, 32'd0, 32'h0002_0000));
        add_beat(mk(REQ_ROW, 16'hfff0, 32'd0, 32'h0002_0000));
        add_beat(mk(REQ_FLUSH, '0), 1'b1, res_of(64'sd983026, 32'd0));
        // unused format behaves as fixed; equal scores order by id
        add_reg(CFG_CODE_FORMAT, 3);
        add_reg(CFG_RESULT_COUNT, K_MAX);
        add_beat(mk(REQ_ROW, 16'h0001, 32'd10));
        add_beat(mk(REQ_ROW, 16'h0001, 32'd10));
        add_beat(mk(REQ_ROW, 16'h0001, 32'hffff_ffff));
        add_beat(mk(REQ_ROW, 16'h0001, 32'd4));
        add_beat(mk(REQ_FLUSH, '0));
        // a count of zero acts as one
        add_reg(CFG_RESULT_COUNT, 0);
        add_beat(mk(REQ_FLUSH, '0));
    endfunction

    // ------------------------------------------------------------------
    // random traffic
    // ------------------------------------------------------------------
    function automatic logic [31:0] pick_id();
        if ($urandom_range(3) == 0) return $urandom;
        return $urandom_range(7);   // small pool so scores and ids collide
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'h0001_0000;
            default: return $urandom_range(32'h0004_0000);
        endcase
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(5))
            0: return 16'h7fff;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_query(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_beat(mk(REQ_QUERY, pick_value(), $urandom, $urandom, 1'($urandom)));
    endtask

    task automatic send_row(input int unsigned len, input logic [15:0] fixed_val,
                            input bit use_fixed, input logic [31:0] sc);
        logic [31:0] d;
        logic        lv;
        d  = pick_id();
        lv = ($urandom_range(7) != 0);
        for (int unsigned i = 0; i < len; i++) begin
            // only the last element's id, scale and live flag count
            if (i + 1 == len)
                send_beat(mk(REQ_ROW, use_fixed ? fixed_val : pick_value(), d, sc, lv));
            else
                send_beat(mk(REQ_ROW, use_fixed ? fixed_val : pick_value(),
                             $urandom, $urandom, 1'($urandom)));
        end
    endtask

    task automatic random_phase(input int unsigned items);
        int unsigned len;
        int unsigned sent;
        int unsigned pick;
        len = ($urandom_range(9) == 0) ? $urandom_range(32, 9) : $urandom_range(8, 1);
        write_reg(CFG_VEC_LENGTH, len);
        write_reg(CFG_RESULT_COUNT, $urandom_range(31));
        write_reg(CFG_CODE_FORMAT, $urandom_range(3));
        load_query(len);
        sent = len;
        while (sent < items) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                send_row(len, '0, 1'b0, pick_scale());
                sent += len;
            end else if (pick < 88) begin
                send_beat(mk(REQ_FLUSH, 16'($urandom), $urandom, $urandom,
                             1'($urandom)));
                sent++;
            end else if (pick < 94) begin
                load_query(len);
                sent += len;
            end else begin
                send_beat(mk(2'd3, 16'($urandom), $urandom, $urandom, 1'($urandom)));
            end
        end
        send_beat(mk(REQ_FLUSH, '0));
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        send_pct    = 0;
        stall_pct   = 0;
        n_errors    = 0;
        n_beats_in  = 0;
        n_beats_out = 0;
        n_flushes   = 0;
        cfg_len     = 11'd64;
        cfg_k       = 5'd8;
        cfg_fmt     = FMT_FIXED;
        query_pos   = 0;
        row_pos     = 0;
        row_acc     = 0;
        top_fill    = 0;
        foreach (query_mem[i]) query_mem[i] = '0;
        foreach (top_score[i]) begin
            top_score[i] = 0;
            top_id[i]    = '0;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_table();
        foreach (steps[i]) begin
            if (steps[i].kind == STEP_REG)
                write_reg(steps[i].reg_idx, steps[i].reg_val);
            else
                send_beat(steps[i].beat, steps[i].typed, steps[i].want);
        end

        // fixed elements bring the first row's sum to 2^31, an int8 row end with the
        // largest scale then saturates the score both ways
        write_reg(CFG_VEC_LENGTH, 3);
        write_reg(CFG_RESULT_COUNT, 2);
        write_reg(CFG_CODE_FORMAT, FMT_FIXED);
        for (int i = 0; i < 3; i++) send_beat(mk(REQ_QUERY, 16'h8000));
        send_beat(mk(REQ_ROW, 16'h8000));
        send_beat(mk(REQ_ROW, 16'h8000));
        write_reg(CFG_CODE_FORMAT, FMT_INT8);
        send_beat(mk(REQ_ROW, 16'h0080, 32'd1, 32'hffff_ffff));
        write_reg(CFG_CODE_FORMAT, FMT_FIXED);
        send_beat(mk(REQ_ROW, 16'h7fff));
        send_beat(mk(REQ_ROW, 16'h7fff));
        write_reg(CFG_CODE_FORMAT, FMT_INT8);
        send_beat(mk(REQ_ROW, 16'h007f, 32'd2, 32'hffff_ffff));
        send_beat(mk(REQ_FLUSH, '0));

        // idle patterns: none, sender, receiver, both
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 64; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 64; end
                default: begin send_pct = 12; stall_pct = 12; end
            endcase
            random_phase(20);
        end

        i_valid <= 1'b0;
        while (match_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d input beats and %0d flushes, %0d result beats checked",
                 n_beats_in, n_flushes, n_beats_out);
        $display("formats fixed/int8/int4/unused, lengths 1 to 32, counts 0 to 31");
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
